@@ rtl/crrc_pkg.sv @@
// ----------------------------------------------------------------------------
// crrc_pkg
// Shared types, codes and constants of the cursor report reply checker.
// ----------------------------------------------------------------------------
package crrc_pkg;

    // payload widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int VERDICT_W  = 2;
    localparam int LEN_W      = 4;
    localparam int STEP_W     = 4;
    localparam int CFG_TICK_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // parameter defaults
    localparam int DEF_REPLY_DEPTH = 10;
    localparam int DEF_TICK_WIDTH  = 16;

    // register indexes and reset values
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_XOFF_EXT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_XOFF_ON  = 2'd2;

    localparam logic [CFG_TICK_W-1:0] RST_TIMEOUT  = 16'd200;
    localparam logic [CFG_TICK_W-1:0] RST_XOFF_EXT = 16'd100;
    localparam logic                  RST_XOFF_ON  = 1'b0;

    // item operations
    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE     = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OP_W-1:0] OP_LINK_ERR = 2'd3;

    // verdicts
    localparam logic [VERDICT_W-1:0] VERDICT_OFFLINE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ONLINE  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd2;

    // validator steps
    localparam logic [STEP_W-1:0] STEP_ESC     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BRACKET = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ROW0    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ROW1    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ROW2    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SEMI    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_COL0    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_COL1    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_COL2    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FINAL   = 4'd9;

    // characters
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_XOFF     = 8'h13;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_FINAL_R  = 8'h52;
    localparam logic [BYTE_W-1:0] CH_DIGIT0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT9   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_C0_MAX   = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_C1_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0] CH_C1_MAX   = 8'h9F;

    typedef struct packed {
        logic [CFG_TICK_W-1:0] timeout_ticks;
        logic [CFG_TICK_W-1:0] xoff_ext_ticks;
        logic                  xoff_on;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic process;
        logic waiting;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic finish;
        logic drain_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/crrc_item_if.sv @@
// ----------------------------------------------------------------------------
// crrc_item_if
// Input channel: operation and received byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crrc_item_if import crrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

@@ rtl/crrc_result_if.sv @@
// ----------------------------------------------------------------------------
// crrc_result_if
// Result channel: verdict and stored reply bytes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crrc_result_if import crrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [LEN_W-1:0]     reply_length;
    logic [BYTE_W-1:0]    reply_byte;
    logic                 last;

    modport source (output valid, output verdict, output reply_length,
                    output reply_byte, output last, input ready);
    modport sink   (input valid, input verdict, input reply_length,
                    input reply_byte, input last, output ready);
endinterface

@@ rtl/crrc_regs.sv @@
// ----------------------------------------------------------------------------
// crrc_regs
// APB-style configuration registers: timeout, xoff extension, xoff enable.
// ----------------------------------------------------------------------------
module crrc_regs import crrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    logic [CFG_TICK_W-1:0] timeout_reg;
    logic [CFG_TICK_W-1:0] xoff_ext_reg;
    logic                  xoff_on_reg;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= RST_TIMEOUT;
            xoff_ext_reg <= RST_XOFF_EXT;
            xoff_on_reg  <= RST_XOFF_ON;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TIMEOUT:  timeout_reg  <= pwdata[CFG_TICK_W-1:0];
                REG_XOFF_EXT: xoff_ext_reg <= pwdata[CFG_TICK_W-1:0];
                REG_XOFF_ON:  xoff_on_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TIMEOUT:  prdata = APB_DATA_W'(timeout_reg);
            REG_XOFF_EXT: prdata = APB_DATA_W'(xoff_ext_reg);
            REG_XOFF_ON:  prdata = APB_DATA_W'(xoff_on_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.timeout_ticks  = timeout_reg;
    assign cfg.xoff_ext_ticks = xoff_ext_reg;
    assign cfg.xoff_on        = xoff_on_reg;

endmodule

@@ rtl/crrc_dp.sv @@
// ----------------------------------------------------------------------------
// crrc_dp
// Datapath: deadline counter, reply validator, reply store and result register.
// ----------------------------------------------------------------------------
module crrc_dp import crrc_pkg::*;
#(
    parameter int REPLY_DEPTH = DEF_REPLY_DEPTH,
    parameter int TICK_WIDTH  = DEF_TICK_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    input  logic [OP_W-1:0]       op,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  logic                  result_ready,
    output sts_t                  sts,
    output logic                  result_valid,
    output logic [VERDICT_W-1:0]  verdict,
    output logic [LEN_W-1:0]      reply_length,
    output logic [BYTE_W-1:0]     reply_byte,
    output logic                  last
);

    localparam int IDX_W = $clog2(REPLY_DEPTH);
    localparam int CNT_W = $clog2(REPLY_DEPTH + 1);
    localparam int SUM_W = ((TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W) + 1;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX   = '1;
    localparam logic [SUM_W-1:0]      TICK_MAX_W = SUM_W'(TICK_MAX);
    localparam logic [CNT_W-1:0]      DEPTH_CNT  = CNT_W'(REPLY_DEPTH);

    logic [TICK_WIDTH-1:0] ticks_reg, ticks_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  seen_reg, seen_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VERDICT_W-1:0]  run_verdict_reg, run_verdict_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [BYTE_W-1:0]     store [REPLY_DEPTH];

    logic                  out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0]  out_verdict_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;

    logic                  is_ctrl, skip, is_digit, ok, store_we, fin;
    logic [STEP_W-1:0]     step_adj;
    logic [VERDICT_W-1:0]  fin_verdict;
    logic [TICK_WIDTH-1:0] tick_dec, load_ticks, ext_ticks;
    logic [SUM_W-1:0]      load_wide, ext_wide;

    // byte classification
    assign is_ctrl  = (rx_byte <= CH_C0_MAX) || (rx_byte == CH_DEL) ||
                      ((rx_byte >= CH_C1_MIN) && (rx_byte <= CH_C1_MAX));
    assign skip     = is_ctrl && (rx_byte != CH_ESC);
    assign is_digit = (rx_byte >= CH_DIGIT0) && (rx_byte <= CH_DIGIT9);

    // short numbers jump ahead to the separator or final step
    always_comb
    begin
        step_adj = step_reg;
        if ((rx_byte == CH_SEMI) && ((step_reg == STEP_ROW1) || (step_reg == STEP_ROW2)))
            step_adj = STEP_SEMI;
        else if ((rx_byte == CH_FINAL_R) &&
                 ((step_reg == STEP_COL1) || (step_reg == STEP_COL2)))
            step_adj = STEP_FINAL;
    end

    always_comb
    begin
        unique case (step_adj)
            STEP_ESC:     ok = (rx_byte == CH_ESC);
            STEP_BRACKET: ok = (rx_byte == CH_LBRACKET);
            STEP_ROW0,
            STEP_ROW1,
            STEP_ROW2:    ok = is_digit;
            STEP_SEMI:    ok = (rx_byte == CH_SEMI);
            STEP_COL0,
            STEP_COL1,
            STEP_COL2:    ok = is_digit;
            STEP_FINAL:   ok = (rx_byte == CH_FINAL_R);
            default:      ok = 1'b0;
        endcase
    end

    // deadline arithmetic, saturating at the counter's full scale
    assign tick_dec   = ticks_reg - TICK_WIDTH'(ticks_reg != '0);
    assign load_wide  = SUM_W'(cfg.timeout_ticks);
    assign load_ticks = (load_wide > TICK_MAX_W) ? TICK_MAX : load_wide[TICK_WIDTH-1:0];
    assign ext_wide   = SUM_W'(ticks_reg) + SUM_W'(cfg.xoff_ext_ticks);
    assign ext_ticks  = (ext_wide > TICK_MAX_W) ? TICK_MAX : ext_wide[TICK_WIDTH-1:0];

    always_comb
    begin
        unique case (op)
            OP_START:
            begin
                fin         = (load_ticks == '0);
                fin_verdict = VERDICT_OFFLINE;
            end
            OP_BYTE:
            begin
                fin         = !skip && (!ok || (step_adj == STEP_FINAL));
                fin_verdict = VERDICT_ONLINE;
            end
            OP_TICK:
            begin
                fin         = (tick_dec == '0);
                fin_verdict = seen_reg ? VERDICT_ONLINE : VERDICT_OFFLINE;
            end
            OP_LINK_ERR:
            begin
                fin         = 1'b1;
                fin_verdict = VERDICT_UNKNOWN;
            end
            default:
            begin
                fin         = 1'b0;
                fin_verdict = VERDICT_OFFLINE;
            end
        endcase
    end

    assign store_we = cmd.process && (op == OP_BYTE) && !skip && (count_reg < DEPTH_CNT);

    always_comb
    begin
        ticks_next       = ticks_reg;
        step_next        = step_reg;
        seen_next        = seen_reg;
        count_next       = count_reg;
        run_verdict_next = run_verdict_reg;
        idx_next         = idx_reg;
        if (cmd.process)
        begin
            unique case (op)
                OP_START:
                begin
                    ticks_next = load_ticks;
                    step_next  = STEP_ESC;
                    seen_next  = 1'b0;
                    count_next = '0;
                end
                OP_TICK:
                    ticks_next = tick_dec;
                OP_BYTE:
                begin
                    seen_next = 1'b1;
                    if (skip)
                    begin
                        if ((rx_byte == CH_XOFF) && cfg.xoff_on)
                            ticks_next = ext_ticks;
                    end
                    else
                    begin
                        if (ok && (step_adj == STEP_FINAL))
                            count_next = '0;
                        else if (count_reg < DEPTH_CNT)
                            count_next = count_reg + CNT_W'(1);
                        // the step only moves on for an accepted byte short of the end
                        if (ok && (step_adj != STEP_FINAL))
                            step_next = step_adj + STEP_W'(1);
                    end
                end
                default: ;
            endcase
            if (fin)
            begin
                run_verdict_next = fin_verdict;
                idx_next         = '0;
            end
        end
        else if (cmd.load_out)
            idx_next = idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg       <= '0;
            step_reg        <= STEP_ESC;
            seen_reg        <= 1'b0;
            count_reg       <= '0;
            run_verdict_reg <= VERDICT_OFFLINE;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ticks_reg       <= ticks_next;
            step_reg        <= step_next;
            seen_reg        <= seen_next;
            count_reg       <= count_next;
            run_verdict_reg <= run_verdict_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store[count_reg[IDX_W-1:0]] <= rx_byte;
    end

    // result register, loaded once per drain beat
    assign out_valid_next = cmd.load_out ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_verdict_reg <= run_verdict_reg;
            out_len_reg     <= LEN_W'(count_reg);
            out_byte_reg    <= (count_reg == '0) ? '0 : store[idx_reg];
            out_last_reg    <= sts.drain_last;
        end
    end

    assign sts.is_start   = (op == OP_START);
    assign sts.finish     = fin;
    assign sts.drain_last = (count_reg == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign reply_length = out_len_reg;
    assign reply_byte   = out_byte_reg;
    assign last         = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("stored byte count beyond reply store depth");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_FINAL)
        else $error("validator step beyond final step");

    a_deadline_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.waiting |-> (ticks_reg != '0))
        else $error("waiting with an expired deadline");

endmodule

@@ rtl/crrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// crrc_ctrl
// Controller: idle, waiting for the reply, and draining the result beats.
// ----------------------------------------------------------------------------
module crrc_ctrl import crrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign item_ready   = (state_reg != ST_DRAIN);
    assign accept       = item_valid && item_ready;
    assign cmd.waiting  = (state_reg == ST_WAIT);
    // items other than start only count while a wait is armed
    assign cmd.process  = accept && (sts.is_start || (state_reg == ST_WAIT));
    assign cmd.load_out = (state_reg == ST_DRAIN) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE,
            ST_WAIT:
            begin
                if (cmd.process)
                    state_next = sts.finish ? ST_DRAIN : ST_WAIT;
            end
            ST_DRAIN:
            begin
                if (cmd.load_out && sts.drain_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_drain_no_rewait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg != ST_WAIT))
        else $error("drain returned straight to waiting");

endmodule

@@ rtl/cursor_report_reply_checker_unit.sv @@
// A start item arms a wait for a cursor position reply (ESC [ row ; col R);
// received bytes, millisecond ticks and link errors are then taken one per
// clock cycle. When the wait ends (complete reply, bad byte, deadline or link
// error) the block stops taking items and sends the verdict with the stored
// bytes (none after a complete reply, whose final byte clears the count)
// from its single-read reply store through the result register: max(1, n)
// beats for n bytes, one per cycle unless the sink stalls. Items are accepted
// again once the last beat is loaded. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// cursor_report_reply_checker_unit
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module cursor_report_reply_checker_unit import crrc_pkg::*;
#(
    parameter int REPLY_DEPTH = DEF_REPLY_DEPTH,
    parameter int TICK_WIDTH  = DEF_TICK_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    crrc_item_if.sink             items,
    crrc_result_if.source         results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic item_ready;

    crrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crrc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    assign items.ready = item_ready;

    crrc_dp #(
        .REPLY_DEPTH (REPLY_DEPTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .op           (items.op),
        .rx_byte      (items.rx_byte),
        .result_ready (results.ready),
        .sts          (sts),
        .result_valid (results.valid),
        .verdict      (results.verdict),
        .reply_length (results.reply_length),
        .reply_byte   (results.reply_byte),
        .last         (results.last)
    );

endmodule
